>>> hw/rtl/lps_pkg.sv
// shared types and constants for the lookahead point selector
package lps_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int IDX_W   = 12;
  localparam int DIST_W  = 32;

  // distance datapath widths
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int STEP_CNT_W = $clog2(SQRT_STEPS);

  // path length limit and index saturation
  localparam int MAX_POINTS = 4096;
  localparam int INDEX_CAP  = (MAX_POINTS - 1) < 4095 ? (MAX_POINTS - 1) : 4095;

  // lookahead reset value, 0.45 m in Q16.16
  localparam logic [DIST_W-1:0] LOOKAHEAD_RESET = 32'd29491;

  // front-to-back item queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one path point
  typedef struct packed {
    logic               eop;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } lps_item_t;

  // one chosen point
  typedef struct packed {
    logic               reached;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } lps_result_t;

endpackage

>>> hw/rtl/lps_queue.sv
// front side: accepts points and holds them in a short queue
module lps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lps_pkg::lps_item_t in_item,
  output logic              out_valid,
  input  logic              out_pop,
  output lps_pkg::lps_item_t out_item
);
  import lps_pkg::*;

  lps_item_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  // handshake on both sides
  assign in_ready  = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_item  = entry_r[rd_ptr_r];
  assign push      = in_valid & in_ready;
  assign pop       = out_pop & out_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_item;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> hw/rtl/lps_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module lps_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lps_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [lps_pkg::ROOT_W-1:0] root
);
  import lps_pkg::*;

  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [REM_W-1:0]      rem_sh, trial;

  // one digit step
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_CNT_W'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

`ifndef NO_ASSERTIONS
  // a new root is only started on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("sqrt started while busy");
`endif

endmodule

>>> hw/rtl/lps_engine.sv
// back side: step length, running distance, point choice and result register
module lps_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  lps_pkg::lps_item_t          q_item,
  input  logic [lps_pkg::DIST_W-1:0]  lookahead,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lps_pkg::lps_result_t        out_result
);
  import lps_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_SQR    = 3'd2;
  localparam logic [2:0] ST_RSTART = 3'd3;
  localparam logic [2:0] ST_RWAIT  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  lps_item_t          cur_r, cur_nxt;
  logic [COORD_W-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_W-1:0] prev_y_r, prev_y_nxt;
  logic [DIST_W-1:0]  travelled_r, travelled_nxt;
  logic [DIST_W-1:0]  tsum_r, tsum_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic               sent_r, sent_nxt;
  logic [IDX_W-1:0]   count_r, count_nxt;
  logic               hit_r, hit_nxt;
  logic [DIFF_W-1:0]  ax_r, ay_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic               out_valid_r, out_valid_nxt;
  lps_result_t        out_r, out_nxt;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIST_W:0]          acc;
  logic                     sq_start, sq_done;
  logic [RAD_W-1:0]         radicand;
  logic [ROOT_W-1:0]        sq_root;
  logic                     emit, can_go;

  // coordinate differences and their magnitudes
  assign dx = DIFF_W'(signed'(cur_r.x)) - DIFF_W'(signed'(prev_x_r));
  assign dy = DIFF_W'(signed'(cur_r.y)) - DIFF_W'(signed'(prev_y_r));

  always_ff @(posedge clk) begin
    ax_r  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay_r  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
  end

  // squared length feeds the root unit
  assign radicand = RAD_W'(sqx_r) + RAD_W'(sqy_r);
  assign sq_start = (state_r == ST_RSTART);

  lps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // saturating running distance
  assign acc = (DIST_W+1)'(travelled_r) + (DIST_W+1)'(sq_root);

  // result hand-off
  assign emit   = hit_r | cur_r.eop;
  assign can_go = !emit || !out_valid_r || out_ready;
  assign q_pop  = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    travelled_nxt = travelled_r;
    tsum_nxt      = tsum_r;
    have_prev_nxt = have_prev_r;
    sent_nxt      = sent_r;
    count_nxt     = count_r;
    hit_nxt       = hit_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
          if (sent_r) begin
            // points after an emission only look for the path end
            if (q_item.eop) begin
              prev_x_nxt    = '0;
              prev_y_nxt    = '0;
              travelled_nxt = '0;
              have_prev_nxt = 1'b0;
              sent_nxt      = 1'b0;
              count_nxt     = '0;
            end
          end else if (have_prev_r) begin
            state_nxt = ST_DIFF;
          end else begin
            // first point of a path is never tested
            hit_nxt   = 1'b0;
            tsum_nxt  = travelled_r;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIFF: begin
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        state_nxt = ST_RSTART;
      end
      ST_RSTART: begin
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (sq_done) begin
          tsum_nxt  = acc[DIST_W] ? '1 : acc[DIST_W-1:0];
          hit_nxt   = (acc[DIST_W] ? '1 : acc[DIST_W-1:0]) >= lookahead;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_go) begin
          if (emit) begin
            out_nxt.x       = cur_r.x;
            out_nxt.y       = cur_r.y;
            out_nxt.index   = count_r;
            out_nxt.reached = hit_r;
            out_valid_nxt   = 1'b1;
          end
          if (cur_r.eop) begin
            prev_x_nxt    = '0;
            prev_y_nxt    = '0;
            travelled_nxt = '0;
            have_prev_nxt = 1'b0;
            sent_nxt      = 1'b0;
            count_nxt     = '0;
          end else begin
            prev_x_nxt    = cur_r.x;
            prev_y_nxt    = cur_r.y;
            travelled_nxt = tsum_r;
            have_prev_nxt = 1'b1;
            sent_nxt      = hit_r;
            if (count_r < IDX_W'(INDEX_CAP)) begin
              count_nxt = count_r + 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      travelled_r <= '0;
      have_prev_r <= 1'b0;
      sent_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      travelled_r <= travelled_nxt;
      have_prev_r <= have_prev_nxt;
      sent_r      <= sent_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    tsum_r <= tsum_nxt;
    hit_r  <= hit_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef NO_ASSERTIONS
  // a root arrives only while it is awaited
  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_RWAIT))
    else $error("root result outside wait state");

  // an emitted path always has a previous point
  a_sent_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> have_prev_r)
    else $error("emission flag without previous point");

  // point index stays within its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IDX_W'(INDEX_CAP))
    else $error("point count beyond cap");
`endif

endmodule

>>> hw/rtl/lookahead_point_selector_core.sv
// top level of the lookahead point selector
// Path points enter one at a time on the in_ stream and wait in a two-entry
// queue; a back-end takes them one after another. A point after an emission
// is only popped and checked for the path end, and the first point of a
// path goes straight to the hand-off. Any other point passes through the
// pop, a difference stage, a squaring stage, a start cycle, then the
// bit-serial square root of the 52-bit squared step, which retires two
// radicand bits a cycle, then accumulate and compare, then the hand-off to
// the output register. A result still waiting on out_ holds the back-end
// in that hand-off. At most one result leaves per path on the out_ stream;
// reached in tuser tells a lookahead hit from the last-point fallback. The
// lookahead register is written through cfg_we/cfg_wdata and should only
// change between paths while the block is empty.
module lookahead_point_selector_core (
  input  logic        clk,
  input  logic        rst_n,
  // input points
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // point_x [23:0], point_y [47:24]
  input  logic        in_tlast,   // end_of_path
  // chosen points
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // target_x [23:0], target_y [47:24], target_index [59:48]
  output logic        out_tuser,  // reached
  // lookahead register
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import lps_pkg::*;

  logic [DIST_W-1:0] lookahead_r;
  lps_item_t         in_item, q_item;
  logic              q_valid, q_pop;
  lps_result_t       result;

  // lookahead distance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= LOOKAHEAD_RESET;
    end else if (cfg_we) begin
      lookahead_r <= cfg_wdata;
    end
  end

  // unpack the incoming point
  assign in_item.x   = in_tdata[COORD_W-1:0];
  assign in_item.y   = in_tdata[2*COORD_W-1:COORD_W];
  assign in_item.eop = in_tlast;

  lps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  lps_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .lookahead  (lookahead_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // pack the chosen point
  assign out_tdata = {4'b0000, result.index, result.y, result.x};
  assign out_tuser = result.reached;

endmodule
